@@ hdl/shfr_pkg.sv @@
// shfr_pkg: types and constants shared by the sync header frame receiver
// parse phases, register indexes, frame descriptor and reset values
// no dependencies
`default_nettype none

package shfr_pkg;

  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 7;
  localparam int IDX_OUT_W = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [LEN_W-1:0]  LIMIT_RESET       = 7'd64;
  localparam logic [BYTE_W-1:0] SYNC_FIRST_RESET  = 8'hA5;
  localparam logic [BYTE_W-1:0] SYNC_SECOND_RESET = 8'h5A;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAYLOAD_LIMIT = 2'd0,
    REG_SYNC_FIRST    = 2'd1,
    REG_SYNC_SECOND   = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_SYNC1  = 3'd0,
    PH_SYNC2  = 3'd1,
    PH_CMD    = 3'd2,
    PH_LEN_LO = 3'd3,
    PH_LEN_HI = 3'd4,
    PH_DATA   = 3'd5,
    PH_SUM    = 3'd6
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] command;
    logic [LEN_W-1:0]  length;
  } desc_t;

endpackage

`default_nettype wire

@@ hdl/shfr_front.sv @@
// shfr_front: configuration registers and byte parser of the frame receiver
// hunts sync bytes, checks length and checksum, writes payload, pushes frames
// depends on shfr_pkg
`default_nettype none

module shfr_front import shfr_pkg::*; #(
  parameter int MAX_PAYLOAD = 64,
  parameter int AW          = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_W-1:0]    rx_byte,
  input  logic                 space_ok,
  output logic                 push,
  output desc_t                push_desc,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output logic [BYTE_W-1:0]    wr_data
);

  localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_PAYLOAD);

  logic [LEN_W-1:0]  payload_limit;
  logic [BYTE_W-1:0] sync_first;
  logic [BYTE_W-1:0] sync_second;

  phase_t            phase, phase_next;
  logic [BYTE_W-1:0] held_command, held_command_next;
  logic [BYTE_W-1:0] len_lo, len_lo_next;
  logic [LEN_W-1:0]  bytes_taken, bytes_taken_next;
  logic [BYTE_W-1:0] running_sum, running_sum_next;

  logic              accept;
  logic [LEN_W-1:0]  taken_inc;

  assign cfg_ready = 1'b1;
  assign in_ready  = space_ok;
  assign accept    = in_valid && in_ready;
  assign taken_inc = bytes_taken + 7'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_limit <= LIMIT_RESET;
      sync_first    <= SYNC_FIRST_RESET;
      sync_second   <= SYNC_SECOND_RESET;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_PAYLOAD_LIMIT: payload_limit <= cfg_data[LEN_W-1:0];
        REG_SYNC_FIRST:    sync_first    <= cfg_data;
        REG_SYNC_SECOND:   sync_second   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SYNC1;
      held_command <= '0;
      len_lo       <= '0;
      bytes_taken  <= '0;
      running_sum  <= '0;
    end else begin
      phase        <= phase_next;
      held_command <= held_command_next;
      len_lo       <= len_lo_next;
      bytes_taken  <= bytes_taken_next;
      running_sum  <= running_sum_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    held_command_next = held_command;
    len_lo_next       = len_lo;
    bytes_taken_next  = bytes_taken;
    running_sum_next  = running_sum;
    push              = 1'b0;
    wr_en             = 1'b0;
    if (accept) begin
      case (phase)
        PH_SYNC1: begin
          if (rx_byte == sync_first) phase_next = PH_SYNC2;
        end
        PH_SYNC2: begin
          if (rx_byte == sync_second) phase_next = PH_CMD;
          else if (rx_byte == sync_first) phase_next = PH_SYNC2;
          else phase_next = PH_SYNC1;
        end
        PH_CMD: begin
          held_command_next = rx_byte;
          running_sum_next  = rx_byte;
          phase_next        = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_lo_next      = rx_byte;
          running_sum_next = running_sum + rx_byte;
          phase_next       = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          running_sum_next = running_sum + rx_byte;
          if (rx_byte != '0 || len_lo > MAX_LEN || len_lo > {1'b0, payload_limit}) begin
            phase_next        = PH_SYNC1;
            held_command_next = '0;
            len_lo_next       = '0;
            bytes_taken_next  = '0;
            running_sum_next  = '0;
          end else begin
            bytes_taken_next = '0;
            phase_next       = (len_lo == '0) ? PH_SUM : PH_DATA;
          end
        end
        PH_DATA: begin
          wr_en            = 1'b1;
          bytes_taken_next = taken_inc;
          running_sum_next = running_sum + rx_byte;
          if ({1'b0, taken_inc} >= len_lo) phase_next = PH_SUM;
        end
        PH_SUM: begin
          push              = (running_sum == rx_byte);
          phase_next        = PH_SYNC1;
          held_command_next = '0;
          len_lo_next       = '0;
          bytes_taken_next  = '0;
          running_sum_next  = '0;
        end
        default: begin
          phase_next        = PH_SYNC1;
          held_command_next = '0;
          len_lo_next       = '0;
          bytes_taken_next  = '0;
          running_sum_next  = '0;
        end
      endcase
    end
  end

  assign push_desc.command = held_command;
  assign push_desc.length  = len_lo[LEN_W-1:0];
  assign wr_addr           = bytes_taken[AW-1:0];
  assign wr_data           = rx_byte;

endmodule

`default_nettype wire

@@ hdl/shfr_queue.sv @@
// shfr_queue: two-entry queue of good frame descriptors
// its pointers also name the payload bank each frame lives in
// depends on shfr_pkg
`default_nettype none

module shfr_queue import shfr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output logic  space_ok,
  output logic  not_empty,
  output desc_t head_desc,
  output logic  wr_bank,
  output logic  rd_bank
);

  desc_t      entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) entries[wptr] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign space_ok  = (count != 2'd2);
  assign not_empty = (count != 2'd0);
  assign head_desc = entries[rptr];
  assign wr_bank   = wptr;
  assign rd_bank   = rptr;

endmodule

`default_nettype wire

@@ hdl/shfr_back.sv @@
// shfr_back: double-banked payload memory and result word emitter
// walks the head frame one payload byte per word into the output register
// depends on shfr_pkg
`default_nettype none

module shfr_back import shfr_pkg::*; #(
  parameter int AW = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [AW:0]          wr_addr,
  input  logic [BYTE_W-1:0]    wr_data,
  input  logic                 not_empty,
  input  desc_t                head_desc,
  input  logic                 rd_bank,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BYTE_W-1:0]    command,
  output logic [LEN_W-1:0]     payload_length,
  output logic [BYTE_W-1:0]    payload_byte,
  output logic [IDX_OUT_W-1:0] byte_index,
  output logic                 byte_present,
  output logic                 last_of_frame
);

  logic [BYTE_W-1:0] mem [2**(AW+1)];
  logic [BYTE_W-1:0] rd_data;
  logic [AW-1:0]     idx;
  logic              advance;
  logic              empty_frame;
  logic              cur_last;

  assign advance     = not_empty && (!out_valid || out_ready);
  assign empty_frame = (head_desc.length == '0);
  assign cur_last    = empty_frame || ((LEN_W'(idx) + 7'd1) == head_desc.length);
  assign pop         = advance && cur_last;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (advance) rd_data <= mem[{rd_bank, idx}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (advance) begin
      out_valid <= 1'b1;
      idx       <= cur_last ? '0 : idx + 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      command        <= head_desc.command;
      payload_length <= head_desc.length;
      byte_index     <= IDX_OUT_W'(idx);
      byte_present   <= !empty_frame;
      last_of_frame  <= cur_last;
    end
  end

  assign payload_byte = byte_present ? rd_data : '0;

endmodule

`default_nettype wire

@@ hdl/sync_header_frame_receiver.sv @@
// sync_header_frame_receiver: top level of the sync header frame receiver
// ties the parser front, the descriptor queue and the emitter back together
// depends on shfr_pkg, shfr_front, shfr_queue, shfr_back
//
// Takes one received byte per cycle while in_ready is high: two sync bytes,
// a command, a 16-bit little-endian length, the payload and an additive
// checksum. A good frame shows up as one result word per payload byte (one
// empty word for a zero length), starting after its descriptor is queued,
// then one word per cycle while out_ready is high. Payload sits in memory of
// two 2**AW-byte banks, so up to two good frames may wait to drain; in_ready
// drops only while both banks hold undrained frames, and comes back as soon
// as the last word of the older frame is taken into the output register.
// The back drains while the front takes the next frame, so with out_ready
// high a byte is taken every cycle; a slow out_ready sets the pace otherwise.
// cfg_ready is always high; write configuration only while idle.
`default_nettype none

module sync_header_frame_receiver import shfr_pkg::*; #(
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_W-1:0]    rx_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BYTE_W-1:0]    command,
  output logic [LEN_W-1:0]     payload_length,
  output logic [BYTE_W-1:0]    payload_byte,
  output logic [IDX_OUT_W-1:0] byte_index,
  output logic                 byte_present,
  output logic                 last_of_frame
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic              space_ok;
  logic              push;
  desc_t             push_desc;
  logic              wr_en;
  logic [AW-1:0]     wr_offset;
  logic [BYTE_W-1:0] wr_data;
  logic              pop;
  logic              not_empty;
  desc_t             head_desc;
  logic              wr_bank;
  logic              rd_bank;

  shfr_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .AW         (AW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .space_ok (space_ok),
    .push     (push),
    .push_desc(push_desc),
    .wr_en    (wr_en),
    .wr_addr  (wr_offset),
    .wr_data  (wr_data)
  );

  shfr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_desc(push_desc),
    .pop      (pop),
    .space_ok (space_ok),
    .not_empty(not_empty),
    .head_desc(head_desc),
    .wr_bank  (wr_bank),
    .rd_bank  (rd_bank)
  );

  shfr_back #(
    .AW(AW)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (wr_en),
    .wr_addr       ({wr_bank, wr_offset}),
    .wr_data       (wr_data),
    .not_empty     (not_empty),
    .head_desc     (head_desc),
    .rd_bank       (rd_bank),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .command       (command),
    .payload_length(payload_length),
    .payload_byte  (payload_byte),
    .byte_index    (byte_index),
    .byte_present  (byte_present),
    .last_of_frame (last_of_frame)
  );

endmodule

`default_nettype wire
